/* hdl/swtn_pkg.sv */
// Package: shared widths, constants and command/status types for the skin weight block.
package swtn_pkg;

  // Field widths
  localparam int BONE_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int SHARE_W  = 8;
  localparam int CFG_W    = 4;

  // Register reset value and parameter defaults
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;
  localparam int DEF_TOP_SLOTS      = 4;
  localparam int DEF_MAX_INFLUENCES = 8;

  // Result layout and normalization
  localparam int OUT_SLOTS  = 4;
  localparam int FULL_SHARE = (1 << SHARE_W) - 1;
  localparam int QUOT_BITS  = SHARE_W;
  localparam int STEP_W     = $clog2(QUOT_BITS);
  localparam int TOTAL_W    = WEIGHT_W + $clog2(OUT_SLOTS);
  localparam int NUM_W      = TOTAL_W + QUOT_BITS - 1;
  localparam int SUM_W      = SHARE_W + $clog2(OUT_SLOTS);
  localparam int ADJ_W      = SUM_W + 1;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic sum;
    logic setup;
    logic step;
    logic load;
  } swtn_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic group_end;
  } swtn_status_t;

endpackage

/* hdl/swtn_if.sv */
// Interfaces: influence input channel and result output channel.
interface swtn_in_if;
  logic                         valid;
  logic                         ready;
  logic [swtn_pkg::BONE_W-1:0]   bone_index;
  logic [swtn_pkg::WEIGHT_W-1:0] bone_weight;

  modport source (output valid, output bone_index, output bone_weight, input ready);
  modport sink   (input valid, input bone_index, input bone_weight, output ready);
endinterface

interface swtn_out_if;
  logic                         valid;
  logic                         ready;
  logic [swtn_pkg::SHARE_W-1:0] bone_a;
  logic [swtn_pkg::SHARE_W-1:0] bone_b;
  logic [swtn_pkg::SHARE_W-1:0] bone_c;
  logic [swtn_pkg::SHARE_W-1:0] bone_d;
  logic [swtn_pkg::SHARE_W-1:0] share_a;
  logic [swtn_pkg::SHARE_W-1:0] share_b;
  logic [swtn_pkg::SHARE_W-1:0] share_c;
  logic [swtn_pkg::SHARE_W-1:0] share_d;

  modport source (output valid, output bone_a, output bone_b, output bone_c, output bone_d,
                  output share_a, output share_b, output share_c, output share_d,
                  input ready);
  modport sink   (input valid, input bone_a, input bone_b, input bone_c, input bone_d,
                  input share_a, input share_b, input share_c, input share_d,
                  output ready);
endinterface

/* hdl/skin_weight_top4_normalize.sv */
// Skin weight selector: keeps the four heaviest bone influences and renormalizes them to 255.
//
// Usage:
//   influence: one transaction per bone influence (bone_index, bone_weight).
//   result:    one transaction per vertex group: four bones (low 8 bits) and
//              four shares that sum to 255; slot a takes the rounding remainder.
//   cfg_write_en/cfg_write_data set the group size (0 reads as 1, values above
//   MAX_INFLUENCES read as MAX_INFLUENCES); write only while the block is idle.
// Sequence:
//   An influence that does not end a group leaves the block idle and ready.
//   The last influence of a group starts the normalize sequence: total sum,
//   setup, the shared four-lane restoring divider (one quotient bit per
//   cycle) and the load of the result register. influence.ready is low
//   from that last influence until the load.
// Reset (rst, synchronous) clears the kept list, counters and result valid and
//   sets the group size to 4. A stalled result stays in the output register;
//   the next group is still taken in, and only its final load waits.
module skin_weight_top4_normalize #(
  parameter int TOP_SLOTS      = swtn_pkg::DEF_TOP_SLOTS,
  parameter int MAX_INFLUENCES = swtn_pkg::DEF_MAX_INFLUENCES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [swtn_pkg::CFG_W-1:0] cfg_write_data,
  swtn_in_if.sink                    influence,
  swtn_out_if.source                 result
);
  import swtn_pkg::*;

  swtn_cmd_t    cmd;
  swtn_status_t status;

  // Sequencer
  swtn_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (influence.valid),
    .in_ready  (influence.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage
  swtn_datapath #(
    .TOP_SLOTS      (TOP_SLOTS),
    .MAX_INFLUENCES (MAX_INFLUENCES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .bone_index     (influence.bone_index),
    .bone_weight    (influence.bone_weight),
    .cmd            (cmd),
    .status         (status),
    .bone_a         (result.bone_a),
    .bone_b         (result.bone_b),
    .bone_c         (result.bone_c),
    .bone_d         (result.bone_d),
    .share_a        (result.share_a),
    .share_b        (result.share_b),
    .share_c        (result.share_c),
    .share_d        (result.share_d)
  );

endmodule

/* hdl/swtn_datapath.sv */
// Datapath: top-N insertion, group counting, snapshot, four-lane divider and result register.
module swtn_datapath #(
  parameter int TOP_SLOTS      = swtn_pkg::DEF_TOP_SLOTS,
  parameter int MAX_INFLUENCES = swtn_pkg::DEF_MAX_INFLUENCES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [swtn_pkg::CFG_W-1:0]    cfg_write_data,
  input  logic [swtn_pkg::BONE_W-1:0]   bone_index,
  input  logic [swtn_pkg::WEIGHT_W-1:0] bone_weight,
  input  swtn_pkg::swtn_cmd_t           cmd,
  output swtn_pkg::swtn_status_t        status,
  output logic [swtn_pkg::SHARE_W-1:0]  bone_a,
  output logic [swtn_pkg::SHARE_W-1:0]  bone_b,
  output logic [swtn_pkg::SHARE_W-1:0]  bone_c,
  output logic [swtn_pkg::SHARE_W-1:0]  bone_d,
  output logic [swtn_pkg::SHARE_W-1:0]  share_a,
  output logic [swtn_pkg::SHARE_W-1:0]  share_b,
  output logic [swtn_pkg::SHARE_W-1:0]  share_c,
  output logic [swtn_pkg::SHARE_W-1:0]  share_d
);
  import swtn_pkg::*;

  localparam int KC_W  = $clog2(TOP_SLOTS + 1);
  localparam int CNT_W = $clog2(MAX_INFLUENCES + 1);

  // Group size register and influence counter
  logic [CFG_W-1:0] group_cfg;
  logic [CFG_W:0]   cfg_ext;
  logic [CFG_W:0]   cfg_clamp;
  logic [CNT_W-1:0] group_size;
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] seen_inc;
  logic             group_end;

  // Kept list (sorted, heaviest first)
  logic [KC_W-1:0]     kept_count;
  logic [KC_W-1:0]     kept_count_next;
  logic [BONE_W-1:0]   kept_bones   [TOP_SLOTS];
  logic [WEIGHT_W-1:0] kept_weights [TOP_SLOTS];
  logic [BONE_W-1:0]   bones_next   [TOP_SLOTS];
  logic [WEIGHT_W-1:0] weights_next [TOP_SLOTS];
  logic [TOP_SLOTS-1:0] ge;

  // Snapshot of a finished group and divider lanes
  logic [SHARE_W-1:0]  cap_bone [OUT_SLOTS];
  logic [WEIGHT_W-1:0] cap_wt   [OUT_SLOTS];
  logic [SHARE_W-1:0]  snap_bone [OUT_SLOTS];
  logic [WEIGHT_W-1:0] snap_wt   [OUT_SLOTS];
  logic [TOTAL_W-1:0]  total;
  logic [NUM_W-1:0]    rem [OUT_SLOTS];
  logic [NUM_W-1:0]    divisor;
  logic [QUOT_BITS-1:0] quot [OUT_SLOTS];

  // Finishing arithmetic
  logic [SUM_W-1:0]        assigned;
  logic signed [ADJ_W-1:0] adj;
  logic [SHARE_W-1:0]      share_a_fix;

  // Result register
  logic [SHARE_W-1:0] res_bone  [OUT_SLOTS];
  logic [SHARE_W-1:0] res_share [OUT_SLOTS];

  // Effective group size: zero reads as one, clamp at the maximum
  always_comb begin
    cfg_ext = {1'b0, group_cfg};
    if (cfg_ext == '0) begin
      cfg_clamp = (CFG_W + 1)'(1);
    end else if (cfg_ext > (CFG_W + 1)'(MAX_INFLUENCES)) begin
      cfg_clamp = (CFG_W + 1)'(MAX_INFLUENCES);
    end else begin
      cfg_clamp = cfg_ext;
    end
  end

  assign group_size = CNT_W'(cfg_clamp);
  assign seen_inc   = seen + CNT_W'(1);
  assign group_end  = (seen_inc >= group_size);
  assign status.group_end = group_end;

  // Insertion: ties keep the earlier entry ahead of the new one
  for (genvar i = 0; i < TOP_SLOTS; i++) begin : g_slot
    assign ge[i] = (KC_W'(i) < kept_count) && (kept_weights[i] >= bone_weight);
    if (i == 0) begin : g_head
      assign bones_next[i]   = ge[i] ? kept_bones[i]   : bone_index;
      assign weights_next[i] = ge[i] ? kept_weights[i] : bone_weight;
    end else begin : g_tail
      assign bones_next[i]   = ge[i] ? kept_bones[i]
                                     : (ge[i-1] ? bone_index : kept_bones[i-1]);
      assign weights_next[i] = ge[i] ? kept_weights[i]
                                     : (ge[i-1] ? bone_weight : kept_weights[i-1]);
    end
  end

  assign kept_count_next = (kept_count < KC_W'(TOP_SLOTS)) ? kept_count + KC_W'(1)
                                                            : kept_count;

  // Snapshot view: empty or missing slots read as bone 0, weight 0
  for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_cap
    if (k < TOP_SLOTS) begin : g_live
      assign cap_bone[k] = (KC_W'(k) < kept_count_next) ? bones_next[k][SHARE_W-1:0] : '0;
      assign cap_wt[k]   = (KC_W'(k) < kept_count_next) ? weights_next[k] : '0;
    end else begin : g_none
      assign cap_bone[k] = '0;
      assign cap_wt[k]   = '0;
    end
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      group_cfg  <= CFG_RESET;
      seen       <= '0;
      kept_count <= '0;
    end else begin
      if (cfg_write_en) begin
        group_cfg <= cfg_write_data;
      end
      if (cmd.take) begin
        if (group_end) begin
          seen       <= '0;
          kept_count <= '0;
        end else begin
          seen       <= seen_inc;
          kept_count <= kept_count_next;
        end
      end
    end
  end

  // Kept list payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kept_bones   <= bones_next;
      kept_weights <= weights_next;
    end
  end

  // Snapshot, total, numerators and divider iterations
  always_ff @(posedge clk) begin
    if (cmd.take && group_end) begin
      snap_bone <= cap_bone;
      snap_wt   <= cap_wt;
    end
    if (cmd.sum) begin
      total <= TOTAL_W'(snap_wt[0]) + TOTAL_W'(snap_wt[1])
             + TOTAL_W'(snap_wt[2]) + TOTAL_W'(snap_wt[3]);
    end
    if (cmd.setup) begin
      // w*255 as w*256 - w, plus half the total for rounding
      for (int k = 0; k < OUT_SLOTS; k++) begin
        rem[k]  <= NUM_W'({snap_wt[k], SHARE_W'(0)}) - NUM_W'(snap_wt[k])
                 + NUM_W'(total >> 1);
        quot[k] <= '0;
      end
      divisor <= NUM_W'({total, (QUOT_BITS - 1)'(0)});
    end
    if (cmd.step) begin
      // Restoring division, one quotient bit per cycle, shared divisor
      for (int k = 0; k < OUT_SLOTS; k++) begin
        if (rem[k] >= divisor) begin
          rem[k]  <= rem[k] - divisor;
          quot[k] <= {quot[k][QUOT_BITS-2:0], 1'b1};
        end else begin
          quot[k] <= {quot[k][QUOT_BITS-2:0], 1'b0};
        end
      end
      divisor <= divisor >> 1;
    end
  end

  // Remainder of 255 goes to slot a, clamped to the share range
  always_comb begin
    assigned = SUM_W'(quot[0]) + SUM_W'(quot[1]) + SUM_W'(quot[2]) + SUM_W'(quot[3]);
    adj = $signed(ADJ_W'(quot[0])) + $signed(ADJ_W'(FULL_SHARE))
        - $signed({1'b0, assigned});
    if (adj < 0) begin
      share_a_fix = '0;
    end else if (adj > $signed(ADJ_W'(FULL_SHARE))) begin
      share_a_fix = SHARE_W'(FULL_SHARE);
    end else begin
      share_a_fix = adj[SHARE_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < OUT_SLOTS; k++) begin
        if (total == '0) begin
          // zero total: first kept bone takes the full share
          res_bone[k]  <= (k == 0) ? snap_bone[k] : '0;
          res_share[k] <= (k == 0) ? SHARE_W'(FULL_SHARE) : '0;
        end else begin
          res_bone[k]  <= snap_bone[k];
          res_share[k] <= (k == 0) ? share_a_fix : quot[k];
        end
      end
    end
  end

  assign bone_a  = res_bone[0];
  assign bone_b  = res_bone[1];
  assign bone_c  = res_bone[2];
  assign bone_d  = res_bone[3];
  assign share_a = res_share[0];
  assign share_b = res_share[1];
  assign share_c = res_share[2];
  assign share_d = res_share[3];

endmodule

/* hdl/swtn_controller.sv */
// Controller: sequences insertion, total, divider steps and the result handshake.
module swtn_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  swtn_pkg::swtn_status_t status,
  output swtn_pkg::swtn_cmd_t    cmd
);
  import swtn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_SETUP = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              out_full;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    cmd.take   = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.take && status.group_end) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step == STEP_W'(QUOT_BITS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // wait here while the previous result is still held
        if (!out_full || out_ready) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step counter and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
      if (cmd.load) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  assign out_valid = out_full;

endmodule

/* hdl/swtn_checker.sv */
// Checker: port-level assertions for the skin weight block, bound to the top level.
module swtn_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [swtn_pkg::SHARE_W-1:0] share_a,
  input logic [swtn_pkg::SHARE_W-1:0] share_b,
  input logic [swtn_pkg::SHARE_W-1:0] share_c,
  input logic [swtn_pkg::SHARE_W-1:0] share_d
);
  import swtn_pkg::*;

  // No result is pending right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays valid and keeps shares a and b
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(share_a) && $stable(share_b))
    else $error("stalled result changed");

  // Every result distributes exactly the full share
  a_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SUM_W'(share_a) + SUM_W'(share_b) + SUM_W'(share_c)
                   + SUM_W'(share_d)) == SUM_W'(FULL_SHARE))
    else $error("shares do not sum to full scale");

  // A new result is loaded only from the finishing step, when no influence is taken
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> !$past(in_valid && in_ready))
    else $error("influence taken in the cycle a result was loaded");

endmodule

bind skin_weight_top4_normalize swtn_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (influence.valid),
  .in_ready  (influence.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .share_a   (result.share_a),
  .share_b   (result.share_b),
  .share_c   (result.share_c),
  .share_d   (result.share_d)
);

/* bench/tb.sv */
// Testbench for the skin weight top-four selector and renormalizer.
`timescale 1ns / 1ps

module tb;
  import swtn_pkg::*;

  // One renormalized vertex result as seen on the result channel
  typedef struct packed {
    logic [SHARE_W-1:0] bone_a;
    logic [SHARE_W-1:0] bone_b;
    logic [SHARE_W-1:0] bone_c;
    logic [SHARE_W-1:0] bone_d;
    logic [SHARE_W-1:0] share_a;
    logic [SHARE_W-1:0] share_b;
    logic [SHARE_W-1:0] share_c;
    logic [SHARE_W-1:0] share_d;
  } vertex_weights_t;

  // Weight patterns for random groups
  typedef enum {MIX_ZERO, MIX_TINY, MIX_EQUAL, MIX_SATURATE, MIX_WIDE} weight_mix_t;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int GROUP_ITEMS   = 85;

  // Keeps the top-four list, predicts vertex results and checks them in order
  class vertex_weight_tracker_t;
    logic [CFG_W-1:0]    group_cfg;
    logic [BONE_W-1:0]   kept_bone[OUT_SLOTS];
    logic [WEIGHT_W-1:0] kept_wt[OUT_SLOTS];
    int unsigned         kept_n;
    int unsigned         seen;
    vertex_weights_t     expected_q[$];
    int                  errors;
    int                  influences;
    int                  groups_checked;
    int                  zero_groups;

    function new();
      group_cfg = CFG_RESET;
      errors = 0;
      influences = 0;
      groups_checked = 0;
      zero_groups = 0;
      clear_group();
    endfunction

    function void clear_group();
      for (int k = 0; k < OUT_SLOTS; k++) begin
        kept_bone[k] = '0;
        kept_wt[k] = '0;
      end
      kept_n = 0;
      seen = 0;
    endfunction

    function void set_group_size(logic [CFG_W-1:0] v);
      group_cfg = v;
    endfunction

    // 0 reads as 1, anything above the maximum reads as the maximum
    function int unsigned effective_size();
      int unsigned n;
      n = group_cfg;
      if (n == 0) n = 1;
      if (n > DEF_MAX_INFLUENCES) n = DEF_MAX_INFLUENCES;
      return n;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Accepted influence: insert below all weights >= it, maybe close the group
    function void note_influence(logic [BONE_W-1:0] bone, logic [WEIGHT_W-1:0] wt);
      int unsigned pos;
      int unsigned i;
      influences++;
      pos = 0;
      while (pos < kept_n && kept_wt[pos] >= wt) pos++;
      if (pos < OUT_SLOTS) begin
        i = (kept_n < OUT_SLOTS) ? kept_n : OUT_SLOTS - 1;
        while (i > pos) begin
          kept_bone[i] = kept_bone[i-1];
          kept_wt[i] = kept_wt[i-1];
          i--;
        end
        kept_bone[pos] = bone;
        kept_wt[pos] = wt;
        if (kept_n < OUT_SLOTS) kept_n++;
      end
      seen++;
      if (seen >= effective_size()) begin
        expected_q = {expected_q, renormalize()};
        clear_group();
      end
    endfunction

    // Scale kept weights to 255 with rounding; slot a absorbs the remainder
    function vertex_weights_t renormalize();
      vertex_weights_t r;
      int unsigned w[OUT_SLOTS];
      int unsigned sh[OUT_SLOTS];
      int unsigned total;
      int unsigned assigned;
      int adj;
      total = 0;
      assigned = 0;
      r = '0;
      for (int k = 0; k < OUT_SLOTS; k++) begin
        w[k] = (k < kept_n) ? kept_wt[k] : 0;
        total += w[k];
      end
      if (total == 0) begin
        zero_groups++;
        r.bone_a = kept_bone[0][SHARE_W-1:0];
        r.share_a = SHARE_W'(FULL_SHARE);
        return r;
      end
      for (int k = 0; k < OUT_SLOTS; k++) begin
        sh[k] = (w[k] * FULL_SHARE + total / 2) / total;
        assigned += sh[k];
      end
      adj = int'(sh[0]) + FULL_SHARE - int'(assigned);
      if (adj < 0) adj = 0;
      if (adj > FULL_SHARE) adj = FULL_SHARE;
      r.bone_a = kept_bone[0][SHARE_W-1:0];
      r.bone_b = kept_bone[1][SHARE_W-1:0];
      r.bone_c = kept_bone[2][SHARE_W-1:0];
      r.bone_d = kept_bone[3][SHARE_W-1:0];
      r.share_a = adj[SHARE_W-1:0];
      r.share_b = sh[1][SHARE_W-1:0];
      r.share_c = sh[2][SHARE_W-1:0];
      r.share_d = sh[3][SHARE_W-1:0];
      return r;
    endfunction

    function void compare_field(string name, logic [SHARE_W-1:0] exp_v,
                                logic [SHARE_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(vertex_weights_t got);
      vertex_weights_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no vertex group pending, expected none, actual %h",
                 $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      groups_checked++;
      compare_field("bone_a", exp_r.bone_a, got.bone_a);
      compare_field("bone_b", exp_r.bone_b, got.bone_b);
      compare_field("bone_c", exp_r.bone_c, got.bone_c);
      compare_field("bone_d", exp_r.bone_d, got.bone_d);
      compare_field("share_a", exp_r.share_a, got.share_a);
      compare_field("share_b", exp_r.share_b, got.share_b);
      compare_field("share_c", exp_r.share_c, got.share_c);
      compare_field("share_d", exp_r.share_d, got.share_d);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_write_en;
  logic [CFG_W-1:0] cfg_write_data;
  int               in_gap_pct;
  int               out_stall_pct;
  int               quiet_cycles;

  swtn_in_if  influence_ch ();
  swtn_out_if result_ch ();

  vertex_weight_tracker_t tracker;

  skin_weight_top4_normalize DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .influence      (influence_ch),
    .result         (result_ch)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result sink: random backpressure per phase
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99, 0) >= out_stall_pct);
  end

  // Monitors: record accepted influences, check accepted results
  always @(posedge clk) begin
    if (!rst && influence_ch.valid && influence_ch.ready)
      tracker.note_influence(influence_ch.bone_index, influence_ch.bone_weight);
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_result('{result_ch.bone_a, result_ch.bone_b, result_ch.bone_c,
                             result_ch.bone_d, result_ch.share_a, result_ch.share_b,
                             result_ch.share_c, result_ch.share_d});
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (influence_ch.valid && influence_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one influence, with random gaps ahead of it, until accepted
  task automatic send_influence(input logic [BONE_W-1:0] bone,
                                input logic [WEIGHT_W-1:0] wt);
    while ($urandom_range(99, 0) < in_gap_pct) begin
      influence_ch.valid <= 1'b0;
      @(posedge clk);
    end
    influence_ch.valid <= 1'b1;
    influence_ch.bone_index <= bone;
    influence_ch.bone_weight <= wt;
    @(posedge clk);
    while (!influence_ch.ready) @(posedge clk);
  endtask

  // Drain all results, let the normalizer settle, then set the group size
  task automatic write_group_size(input logic [CFG_W-1:0] v);
    influence_ch.valid <= 1'b0;
    // let the monitor note the last influence before the pending count is read
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    tracker.set_group_size(v);
  endtask

  // One full group with a random weight pattern
  task automatic send_random_group(input int unsigned n);
    weight_mix_t mix;
    logic [WEIGHT_W-1:0] base;
    logic [WEIGHT_W-1:0] wt;
    int unsigned pick;
    pick = $urandom_range(9, 0);
    base = WEIGHT_W'($urandom);
    if (pick == 0) mix = MIX_ZERO;
    else if (pick <= 2) mix = MIX_TINY;
    else if (pick == 3) mix = MIX_EQUAL;
    else if (pick == 4) mix = MIX_SATURATE;
    else mix = MIX_WIDE;
    for (int unsigned i = 0; i < n; i++) begin
      case (mix)
        MIX_ZERO:     wt = '0;
        MIX_TINY:     wt = WEIGHT_W'($urandom_range(3, 0));
        MIX_EQUAL:    wt = base;
        MIX_SATURATE: wt = $urandom_range(1, 0) ? '1 : WEIGHT_W'($urandom);
        default:      wt = WEIGHT_W'($urandom);
      endcase
      send_influence(BONE_W'($urandom), wt);
    end
  endtask

  // Group-size plan for the random part: extremes first, in the first pacing phase
  logic [CFG_W-1:0] size_plan[12] = '{4'd8, 4'd1, 4'd15, 4'd0,
                                      4'd4, 4'd3, 4'd6,  4'd2,
                                      4'd7, 4'd12, 4'd5, 4'd8};
  int gap_plan[3]   = '{22, 59, 0};
  int stall_plan[3] = '{59, 22, 0};

  initial begin
    int unsigned sent;
    tracker = new();
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    influence_ch.valid = 1'b0;
    influence_ch.bone_index = '0;
    influence_ch.bone_weight = '0;
    result_ch.ready = 1'b0;
    quiet_cycles = 0;
    in_gap_pct = gap_plan[0];
    out_stall_pct = stall_plan[0];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset group size of four: extreme fields, tie between equal weights
    send_influence(16'hFFFF, 16'hFFFF);
    send_influence(16'h0000, 16'h0001);
    send_influence(16'h1234, 16'h8000);
    send_influence(16'hABCD, 16'h8000);
    // All-zero weights: first bone takes the full share
    send_influence(16'h0155, 16'h0000);
    send_influence(16'h02AA, 16'h0000);
    send_influence(16'h0003, 16'h0000);
    send_influence(16'h0004, 16'h0000);
    // Single-influence groups, including register value zero
    write_group_size(4'd1);
    send_influence(16'h00FF, 16'h0000);
    send_influence(16'h7FFF, 16'h0001);
    write_group_size(4'd0);
    send_influence(16'h8001, 16'hFFFF);
    // Oversized register value clamps to eight; ties and drops past slot four
    write_group_size(4'd15);
    send_influence(16'h0010, 16'd5);
    send_influence(16'h0011, 16'd5);
    send_influence(16'h0012, 16'd9);
    send_influence(16'h0013, 16'd0);
    send_influence(16'h0014, 16'd5);
    send_influence(16'h0015, 16'd9);
    send_influence(16'h0016, 16'hFFFF);
    send_influence(16'h0017, 16'd5);
    // Size change inside a partly taken group ends it at the next influence
    write_group_size(4'd8);
    send_influence(16'h5A5A, 16'd300);
    send_influence(16'hA5A5, 16'd100);
    send_influence(16'h0F0F, 16'd200);
    write_group_size(4'd2);
    send_influence(16'hF0F0, 16'd400);
    // Rounding overshoot pulls slot a down
    write_group_size(4'd3);
    send_influence(16'h0021, 16'd1);
    send_influence(16'h0022, 16'd1);
    send_influence(16'h0023, 16'd2);

    // Random groups across three pacing phases and several group sizes
    for (int ph = 0; ph < 3; ph++) begin
      for (int sub = 0; sub < 4; sub++) begin
        write_group_size(size_plan[ph*4 + sub]);
        in_gap_pct = gap_plan[ph];
        out_stall_pct = stall_plan[ph];
        sent = 0;
        while (sent < GROUP_ITEMS) begin
          send_random_group(tracker.effective_size());
          sent += tracker.effective_size();
        end
      end
    end

    // Drain and let the block go quiet
    influence_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Covered %0d influences in %0d vertex groups, %0d of them with zero total weight",
             tracker.influences, tracker.groups_checked, tracker.zero_groups);
    $display("Group sizes 1 to 8 with register values 0 and 15, under three pacing phases");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/swtn_pkg.sv
hdl/swtn_if.sv
hdl/swtn_datapath.sv
hdl/swtn_controller.sv
hdl/skin_weight_top4_normalize.sv
hdl/swtn_checker.sv
bench/tb.sv
